/* hw/rtl/pvs_pkg.sv */
package pvs_pkg;

  localparam int FRAMES_DEFAULT = 1024;
  localparam int FRAME_W        = 10;
  localparam int AGE_W          = 8;

  // item kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_ACCESS = 2'd1;
  localparam logic [1:0] KIND_VICTIM = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_VICTIM = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  localparam logic POLICY_SECOND_CHANCE = 1'b0;
  localparam logic POLICY_AGING         = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FRAME_W-1:0] frame;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] victim;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic       clr_step;
    logic       latch_item;
    logic       rd_item;
    logic       mark;
    logic       append;
    logic       walk_start;
    logic       walk_step;
    logic       unlink_pred;
    logic       unlink_self;
    logic       out_load;
    logic [1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] kind;
    logic       in_range;
    logic       queue_empty;
    logic       queued;
    logic       walk_found;
    logic       walk_end;
    logic       out_free;
  } dp_status_t;

endpackage

/* hw/rtl/pvs_datapath.sv */
module pvs_datapath #(
  parameter int FRAMES = pvs_pkg::FRAMES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  pvs_pkg::dp_cmd_t    cmd,
  output pvs_pkg::dp_status_t sts,
  input  pvs_pkg::in_item_t   in_data,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pvs_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(FRAMES);
  localparam int LW = $clog2(FRAMES + 1);
  localparam int GW = pvs_pkg::AGE_W;
  localparam logic [LW-1:0] END_MARK = LW'(FRAMES);

  logic [LW-1:0] link_mem [FRAMES];
  logic          acc_mem  [FRAMES];
  logic [GW-1:0] age_mem  [FRAMES];

  pvs_pkg::in_item_t item;
  logic          policy;
  logic [AW-1:0] clr_idx;
  logic [LW-1:0] queue_first, queue_last;
  logic [LW-1:0] cur, prev, vic, vic_prev, vic_succ, head_succ;
  logic [GW:0]   best_age;
  logic          first_step;
  logic [LW-1:0] link_rd;
  logic          acc_rd;
  logic [GW-1:0] age_rd;

  logic [LW-1:0] item_link;
  logic [AW-1:0] item_addr;
  logic [GW-1:0] aged;
  logic          better;
  logic          queue_empty, walk_end, walk_found;

  logic          link_we, acc_we, age_we, rd_en;
  logic [AW-1:0] link_wa, acc_wa, age_wa, rd_addr;
  logic [LW-1:0] link_wd;
  logic          acc_wd;
  logic [GW-1:0] age_wd;

  assign item_link   = LW'(item.frame);
  assign item_addr   = AW'(item.frame);
  assign queue_empty = (queue_first == END_MARK);
  assign walk_end    = (link_rd == END_MARK);
  assign walk_found  = (policy == pvs_pkg::POLICY_SECOND_CHANCE) && !acc_rd;
  // half the age plus 128 if accessed; the sum never exceeds 255
  assign aged        = {acc_rd, age_rd[GW-1:1]};
  assign better      = ({1'b0, aged} < best_age);

  always_comb begin
    sts.clr_last    = (clr_idx == AW'(FRAMES - 1));
    sts.kind        = item.kind;
    sts.in_range    = (int'(item.frame) < FRAMES);
    sts.queue_empty = queue_empty;
    sts.queued      = !queue_empty && (link_rd != END_MARK || queue_last == item_link);
    sts.walk_found  = walk_found;
    sts.walk_end    = walk_end;
    sts.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = '0;
    link_wd = END_MARK;
    acc_we  = 1'b0;
    acc_wa  = '0;
    acc_wd  = 1'b0;
    age_we  = 1'b0;
    age_wa  = '0;
    age_wd  = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.clr_step) begin
      link_we = 1'b1;
      link_wa = clr_idx;
      acc_we  = 1'b1;
      acc_wa  = clr_idx;
      age_we  = 1'b1;
      age_wa  = clr_idx;
    end
    if (cmd.mark) begin
      acc_we = 1'b1;
      acc_wa = item_addr;
      acc_wd = 1'b1;
    end
    if (cmd.rd_item) begin
      rd_en   = 1'b1;
      rd_addr = item_addr;
    end
    if (cmd.append) begin
      age_we = 1'b1;
      age_wa = item_addr;
      if (!queue_empty) begin
        link_we = 1'b1;
        link_wa = AW'(queue_last);
        link_wd = item_link;
      end
    end
    if (cmd.walk_start) begin
      rd_en   = 1'b1;
      rd_addr = AW'(queue_first);
    end
    if (cmd.walk_step) begin
      acc_we = 1'b1;
      acc_wa = AW'(cur);
      if (policy == pvs_pkg::POLICY_AGING) begin
        age_we = 1'b1;
        age_wa = AW'(cur);
        age_wd = aged;
      end
      if (!walk_end && !walk_found) begin
        rd_en   = 1'b1;
        rd_addr = AW'(link_rd);
      end
    end
    if (cmd.unlink_pred && vic_prev != END_MARK) begin
      link_we = 1'b1;
      link_wa = AW'(vic_prev);
      link_wd = vic_succ;
    end
    if (cmd.unlink_self) begin
      link_we = 1'b1;
      link_wa = AW'(vic);
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
      acc_rd  <= acc_mem[rd_addr];
      age_rd  <= age_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= pvs_pkg::POLICY_SECOND_CHANCE;
      clr_idx     <= '0;
      queue_first <= END_MARK;
      queue_last  <= END_MARK;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        policy <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.append) begin
        if (queue_empty) begin
          queue_first <= item_link;
        end
        queue_last <= item_link;
      end
      if (cmd.unlink_pred) begin
        if (vic_prev == END_MARK) begin
          queue_first <= vic_succ;
        end
        if (queue_last == vic) begin
          queue_last <= vic_prev;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item <= in_data;
    end
    if (cmd.walk_start) begin
      cur        <= queue_first;
      prev       <= END_MARK;
      vic        <= queue_first;
      vic_prev   <= END_MARK;
      vic_succ   <= END_MARK;
      best_age   <= {1'b1, {GW{1'b0}}};
      first_step <= 1'b1;
    end
    if (cmd.walk_step) begin
      first_step <= 1'b0;
      if (first_step) begin
        head_succ <= link_rd;
      end
      if (policy == pvs_pkg::POLICY_SECOND_CHANCE) begin
        if (walk_found) begin
          vic      <= cur;
          vic_prev <= prev;
          vic_succ <= link_rd;
        end else if (walk_end) begin
          // every bit was set: fall back to the head
          vic      <= queue_first;
          vic_prev <= END_MARK;
          vic_succ <= first_step ? link_rd : head_succ;
        end
      end else if (better) begin
        best_age <= {1'b0, aged};
        vic      <= cur;
        vic_prev <= prev;
        vic_succ <= link_rd;
      end
      prev <= cur;
      cur  <= link_rd;
    end
    if (cmd.out_load) begin
      out_data.status <= cmd.out_status;
      out_data.victim <= (cmd.out_status == pvs_pkg::STATUS_VICTIM) ?
                         pvs_pkg::FRAME_W'(vic) : '0;
    end
  end

endmodule

/* hw/rtl/pvs_ctrl.sv */
module pvs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pvs_pkg::dp_status_t sts,
  output pvs_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_APPEND,
    ST_WALK,
    ST_UNLINK_PRED,
    ST_UNLINK_SELF,
    ST_OUT
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_status, res_status_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    res_status_next = res_status;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_status_next = pvs_pkg::STATUS_DONE;
        state_next      = ST_OUT;
        case (sts.kind)
          pvs_pkg::KIND_APPEND: begin
            if (sts.in_range) begin
              cmd.rd_item = 1'b1;
              state_next  = ST_APPEND;
            end
          end
          pvs_pkg::KIND_ACCESS: begin
            cmd.mark = sts.in_range;
          end
          pvs_pkg::KIND_VICTIM: begin
            if (sts.queue_empty) begin
              res_status_next = pvs_pkg::STATUS_EMPTY;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = ST_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      ST_APPEND: begin
        cmd.append = !sts.queued;
        state_next = ST_OUT;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_found || sts.walk_end) begin
          state_next = ST_UNLINK_PRED;
        end
      end
      ST_UNLINK_PRED: begin
        cmd.unlink_pred = 1'b1;
        state_next      = ST_UNLINK_SELF;
      end
      ST_UNLINK_SELF: begin
        cmd.unlink_self = 1'b1;
        res_status_next = pvs_pkg::STATUS_VICTIM;
        state_next      = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      res_status <= pvs_pkg::STATUS_DONE;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

/* hw/rtl/page_victim_select_sc_aging.sv */
// Page victim selection, second chance or aging.
// in channel (in_valid/in_ready/in_data): one transaction per item; kind
//   selects append frame, mark frame accessed, or request victim.
// out channel (out_valid/out_ready/out_data): exactly one result per item,
//   victim frame and status, in item order.
// cfg channel (cfg_valid/cfg_ready/cfg_data): policy bit, 0 second chance,
//   1 aging; always ready, write only while no item is in flight.
// After accept: EXEC, then OUT for access and empty-queue requests, APPEND
//   first for an append, one WALK step per frame walked for a victim
//   request (second chance: up to the first frame with a clear bit, else the
//   whole queue; aging: the whole queue), then UNLINK_PRED, UNLINK_SELF.
//   One item at a time; one link-memory read per frame walked sets the rate.
// Reset: the queue is emptied and a clearing pass writes every entry of the
//   link, accessed and age memories; in_ready stays low during it.
// Stall: a result waits in the output register; the next item can be taken
//   meanwhile, but its result holds the block until the register frees.
module page_victim_select_sc_aging #(
  parameter int FRAMES = pvs_pkg::FRAMES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pvs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pvs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  pvs_pkg::dp_cmd_t    cmd;
  pvs_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  pvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pvs_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/pvs_checker.sv */
module pvs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pvs_pkg::out_item_t out_data
);

  // a pending result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == pvs_pkg::STATUS_DONE ||
                   out_data.status == pvs_pkg::STATUS_VICTIM ||
                   out_data.status == pvs_pkg::STATUS_EMPTY))
    else $error("bad status code");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != pvs_pkg::STATUS_VICTIM |-> out_data.victim == '0)
    else $error("victim set without victim status");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("ready during clearing pass");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind page_victim_select_sc_aging pvs_checker u_pvs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/page_victim_select_sc_aging_tb.sv */
`timescale 1ns / 1ps

module page_victim_select_sc_aging_tb;

  localparam int FRAMES      = pvs_pkg::FRAMES_DEFAULT;
  localparam int END_MARK    = FRAMES;
  localparam int AGE_BOOST   = 128;
  localparam int AGE_CEIL    = 255;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 92;
  localparam int POOL_SIZE   = 40;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Golden model of the frame queue plus the store of expected results.
  class replacement_scoreboard;
    int                 link_next [FRAMES];
    int                 head;
    int                 tail;
    bit                 accessed [FRAMES];
    int                 age [FRAMES];
    logic               policy;
    pvs_pkg::out_item_t pending_results [$];
    int                 errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        link_next[i] = END_MARK;
        accessed[i]  = 1'b0;
        age[i]       = 0;
      end
      head   = END_MARK;
      tail   = END_MARK;
      policy = pvs_pkg::POLICY_SECOND_CHANCE;
      errors = 0;
    endfunction

    task report(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    function bit is_queued(input int f);
      if (head == END_MARK) return 1'b0;
      return link_next[f] != END_MARK || tail == f;
    endfunction

    function void unlink(input int prev, input int cur);
      int succ;
      succ = link_next[cur];
      if (prev == END_MARK) head = succ;
      else link_next[prev] = succ;
      if (tail == cur) tail = prev;
      link_next[cur] = END_MARK;
    endfunction

    function int second_chance_pick();
      int prev;
      int cur;
      int steps;
      prev  = END_MARK;
      cur   = head;
      steps = 0;
      while (cur < END_MARK && steps < FRAMES) begin
        if (!accessed[cur]) begin
          unlink(prev, cur);
          return cur;
        end
        accessed[cur] = 1'b0;
        prev = cur;
        cur  = link_next[cur];
        steps++;
      end
      // every bit was set: the head goes
      cur = head;
      unlink(END_MARK, cur);
      return cur;
    endfunction

    function int aging_pick();
      int prev;
      int cur;
      int best;
      int best_prev;
      int best_age;
      int steps;
      int a;
      prev      = END_MARK;
      cur       = head;
      best      = head;
      best_prev = END_MARK;
      best_age  = AGE_CEIL + 1;
      steps     = 0;
      while (cur < END_MARK && steps < FRAMES) begin
        a = age[cur] >> 1;
        if (accessed[cur]) begin
          a = a + AGE_BOOST;
          if (a > AGE_CEIL) a = AGE_CEIL;
        end
        age[cur]      = a;
        accessed[cur] = 1'b0;
        if (a < best_age) begin
          best_age  = a;
          best      = cur;
          best_prev = prev;
        end
        prev = cur;
        cur  = link_next[cur];
        steps++;
      end
      unlink(best_prev, best);
      return best;
    endfunction

    function void note_item(input pvs_pkg::in_item_t it);
      pvs_pkg::out_item_t want;
      int                 f;
      want = '0;
      want.status = pvs_pkg::STATUS_DONE;
      f = int'(it.frame);
      case (it.kind)
        pvs_pkg::KIND_APPEND: begin
          if (f < FRAMES && !is_queued(f)) begin
            link_next[f] = END_MARK;
            age[f] = 0;
            if (head == END_MARK) head = f;
            else link_next[tail] = f;
            tail = f;
          end
        end
        pvs_pkg::KIND_ACCESS: begin
          if (f < FRAMES) accessed[f] = 1'b1;
        end
        pvs_pkg::KIND_VICTIM: begin
          if (head == END_MARK) begin
            want.status = pvs_pkg::STATUS_EMPTY;
          end else begin
            if (policy == pvs_pkg::POLICY_AGING)
              want.victim = pvs_pkg::FRAME_W'(aging_pick());
            else
              want.victim = pvs_pkg::FRAME_W'(second_chance_pick());
            want.status = pvs_pkg::STATUS_VICTIM;
          end
        end
        default: ;
      endcase
      pending_results.push_back(want);
    endfunction

    task check_result(input pvs_pkg::out_item_t got);
      pvs_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: victim=%0d status=%0d",
                         got.victim, got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.victim !== want.victim)
        report($sformatf("victim got %0d want %0d", got.victim, want.victim));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pvs_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pvs_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data  = 1'b0;

  replacement_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left  = 0;

  page_victim_select_sc_aging u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[page_victim_select_sc_aging] ERROR");
      $finish;
    end
  end

  // receiver: always ready, random stalls, then long stalls, in turn
  always @(posedge clk) begin
    case ((cycle_count / 150) % 3)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((cycle_count % 18) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send_item(input logic [1:0] kind, input int frame);
    pvs_pkg::in_item_t it;
    it.kind  = kind;
    it.frame = pvs_pkg::FRAME_W'(frame);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one transaction, then the sender's burst/gap pacing
  task automatic feed(input logic [1:0] kind, input int frame);
    send_item(kind, frame);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_for($urandom_range(1, 10));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // with nothing pending the sender is already idle
  task automatic drain();
    if (sb.pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_policy(input logic p);
    cfg_data  <= p;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.policy = p;
  endtask

  task automatic random_phase(input int count, input bit hold_midway);
    int pool [POOL_SIZE];
    int r;
    int frame;
    int victim_run;
    victim_run = 0;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom_range(0, FRAMES - 1);
    for (int n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2) drain();
      else if ($urandom_range(0, 149) == 0) drain();
      if (victim_run == 0 && $urandom_range(0, 59) == 0)
        victim_run = $urandom_range(10, 50);
      frame = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAMES - 1)
                                          : pool[$urandom_range(0, POOL_SIZE - 1)];
      r = $urandom_range(0, 99);
      if (victim_run > 0) begin
        victim_run--;
        feed(pvs_pkg::KIND_VICTIM, $urandom_range(0, FRAMES - 1));
      end else if (r < 40) feed(pvs_pkg::KIND_APPEND, frame);
      else if (r < 75) feed(pvs_pkg::KIND_ACCESS, frame);
      else if (r < 95) feed(pvs_pkg::KIND_VICTIM, $urandom_range(0, FRAMES - 1));
      else feed(KIND_UNUSED, frame);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_policy(pvs_pkg::POLICY_SECOND_CHANCE);
    feed(pvs_pkg::KIND_VICTIM, 0);        // empty queue
    feed(KIND_UNUSED, 1023);
    feed(pvs_pkg::KIND_APPEND, 0);
    feed(pvs_pkg::KIND_APPEND, 1023);
    feed(pvs_pkg::KIND_APPEND, 512);
    feed(pvs_pkg::KIND_APPEND, 0);        // already queued, ignored
    feed(pvs_pkg::KIND_ACCESS, 1023);
    feed(pvs_pkg::KIND_ACCESS, 5);        // not queued yet, bit still set
    feed(pvs_pkg::KIND_APPEND, 5);
    feed(pvs_pkg::KIND_VICTIM, 1023);     // head has clear bit
    feed(pvs_pkg::KIND_ACCESS, 512);
    feed(pvs_pkg::KIND_VICTIM, 0);        // all bits set, head goes
    feed(pvs_pkg::KIND_VICTIM, 0);
    feed(pvs_pkg::KIND_VICTIM, 0);
    feed(pvs_pkg::KIND_VICTIM, 0);
    drain();

    write_policy(pvs_pkg::POLICY_AGING);
    feed(pvs_pkg::KIND_APPEND, 7);
    feed(pvs_pkg::KIND_APPEND, 300);
    feed(pvs_pkg::KIND_APPEND, 1000);
    feed(pvs_pkg::KIND_ACCESS, 300);
    feed(pvs_pkg::KIND_ACCESS, 7);
    feed(pvs_pkg::KIND_VICTIM, 0);
    feed(pvs_pkg::KIND_ACCESS, 7);
    feed(pvs_pkg::KIND_VICTIM, 682);
    feed(pvs_pkg::KIND_APPEND, 20);
    feed(pvs_pkg::KIND_VICTIM, 0);
    feed(pvs_pkg::KIND_VICTIM, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_policy((p % 2) ? pvs_pkg::POLICY_AGING : pvs_pkg::POLICY_SECOND_CHANCE);
      random_phase(PHASE_ITEMS, p == 2);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[page_victim_select_sc_aging] OK");
    end else begin
      $display("[page_victim_select_sc_aging] ERROR");
    end
    $finish;
  end

endmodule
